[hdl/kpsc_pkg.sv]
package kpsc_pkg;

  localparam int LengthCounterMax = 255;
  localparam int QueueDepth       = 4;
  localparam int CfgIndexWidth    = 8;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       policy_ok;
    logic [2:0] fail_cause;
  } out_item_t;

  // byte classes that matter to the keyring prefix match
  typedef enum logic [2:0] {
    CLS_AT,
    CLS_U,
    CLS_S,
    CLS_GPT,
    CLS_NUL,
    CLS_OTHER
  } pfx_cls_t;

  // one classified byte, as queued between front and back
  typedef struct packed {
    logic     is_pol_sep;
    logic     is_ref_sep;
    logic     is_alnum;
    pfx_cls_t pfx_cls;
    logic     is_last;
  } cls_item_t;

  typedef struct packed {
    logic [7:0] min_len;
    logic [7:0] max_len;
  } len_bounds_t;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_PREFIX  = 3'd1,
    CAUSE_NO_SEP  = 3'd2,
    CAUSE_DESC    = 3'd3,
    CAUSE_EMPTY   = 3'd4
  } cause_t;

endpackage

[hdl/kpsc_front.sv]
module kpsc_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  kpsc_pkg::in_item_t                    in_data,
  input  logic                                  q_full,
  output logic                                  q_push,
  output kpsc_pkg::cls_item_t                   q_data,
  input  logic                                  cfg_valid,
  input  logic [kpsc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [7:0]                            cfg_data,
  output kpsc_pkg::len_bounds_t                 bounds
);

  localparam logic [kpsc_pkg::CfgIndexWidth-1:0] RegRefSep = 'd0;
  localparam logic [kpsc_pkg::CfgIndexWidth-1:0] RegPolSep = 'd1;
  localparam logic [kpsc_pkg::CfgIndexWidth-1:0] RegMinLen = 'd2;
  localparam logic [kpsc_pkg::CfgIndexWidth-1:0] RegMaxLen = 'd3;

  localparam logic [7:0] ChAt  = 8'h40;
  localparam logic [7:0] ChU   = 8'h75;
  localparam logic [7:0] ChS   = 8'h73;
  localparam logic [7:0] ChG   = 8'h67;
  localparam logic [7:0] ChP   = 8'h70;
  localparam logic [7:0] ChT   = 8'h74;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] Ch0   = 8'h30;
  localparam logic [7:0] Ch9   = 8'h39;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5a;
  localparam logic [7:0] ChLoA = 8'h61;
  localparam logic [7:0] ChLoZ = 8'h7a;

  logic [7:0] ref_sep_r;
  logic [7:0] pol_sep_r;
  logic [7:0] min_len_r;
  logic [7:0] max_len_r;
  logic [7:0] b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_sep_r <= 8'd46;
      pol_sep_r <= 8'd58;
      min_len_r <= 8'd1;
      max_len_r <= 8'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegRefSep: ref_sep_r <= cfg_data;
        RegPolSep: pol_sep_r <= cfg_data;
        RegMinLen: min_len_r <= cfg_data;
        RegMaxLen: max_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bounds.min_len = min_len_r;
  assign bounds.max_len = max_len_r;

  assign b      = in_data.char_byte;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_data.is_pol_sep = (b == pol_sep_r);
    q_data.is_ref_sep = (b == ref_sep_r);
    q_data.is_alnum   = (b >= Ch0 && b <= Ch9) || (b >= ChUpA && b <= ChUpZ) ||
                        (b >= ChLoA && b <= ChLoZ);
    q_data.is_last    = in_data.is_last;
    if (b == ChAt) begin
      q_data.pfx_cls = kpsc_pkg::CLS_AT;
    end else if (b == ChU) begin
      q_data.pfx_cls = kpsc_pkg::CLS_U;
    end else if (b == ChS) begin
      q_data.pfx_cls = kpsc_pkg::CLS_S;
    end else if (b == ChG || b == ChP || b == ChT) begin
      q_data.pfx_cls = kpsc_pkg::CLS_GPT;
    end else if (b == ChNul) begin
      q_data.pfx_cls = kpsc_pkg::CLS_NUL;
    end else begin
      q_data.pfx_cls = kpsc_pkg::CLS_OTHER;
    end
  end

endmodule

[hdl/kpsc_fifo.sv]
module kpsc_fifo #(
  parameter int DEPTH = kpsc_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  kpsc_pkg::cls_item_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output kpsc_pkg::cls_item_t  pop_data,
  output logic                 not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kpsc_pkg::cls_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty with pointers apart");

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CW'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue full with pointers apart");

endmodule

[hdl/kpsc_back.sv]
module kpsc_back #(
  parameter int LENGTH_COUNTER_MAX = kpsc_pkg::LengthCounterMax
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  kpsc_pkg::cls_item_t    q_data,
  output logic                   q_pop,
  input  kpsc_pkg::len_bounds_t  bounds,
  output logic                   out_valid,
  input  logic                   out_stall,
  output kpsc_pkg::out_item_t    out_data
);

  localparam int LW = $clog2(LENGTH_COUNTER_MAX + 1);
  localparam int CW = (LW > 8) ? LW : 8;

  typedef enum logic [2:0] {
    PFX_EMPTY,
    PFX_AT,
    PFX_AT_U,
    PFX_AT_US,
    PFX_AT_OTHER,
    PFX_TERM,
    PFX_BAD
  } pfx_t;

  logic                 in_desc_r, in_desc_nxt;
  pfx_t                 pfx_r, pfx_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic                 seg_empty_r, seg_empty_nxt;
  logic                 desc_bad_r, desc_bad_nxt;
  kpsc_pkg::cause_t     fail_r, fail_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kpsc_pkg::out_item_t  out_data_r, out_data_nxt;
  kpsc_pkg::cause_t     fin;

  function automatic pfx_t pfx_step(input pfx_t s, input kpsc_pkg::pfx_cls_t c);
    pfx_t r;
    r = PFX_BAD;
    case (s)
      PFX_EMPTY: begin
        if (c == kpsc_pkg::CLS_AT) r = PFX_AT;
      end
      PFX_AT: begin
        if (c == kpsc_pkg::CLS_U) r = PFX_AT_U;
        else if (c == kpsc_pkg::CLS_S || c == kpsc_pkg::CLS_GPT) r = PFX_AT_OTHER;
      end
      PFX_AT_U: begin
        if (c == kpsc_pkg::CLS_S) r = PFX_AT_US;
        else if (c == kpsc_pkg::CLS_NUL) r = PFX_TERM;
      end
      PFX_AT_US, PFX_AT_OTHER: begin
        if (c == kpsc_pkg::CLS_NUL) r = PFX_TERM;
      end
      PFX_TERM: r = PFX_TERM;
      default: r = PFX_BAD;
    endcase
    return r;
  endfunction

  function automatic kpsc_pkg::cause_t seg_cause(
    input logic          empty,
    input logic          in_desc,
    input pfx_t          pfx,
    input logic          bad,
    input logic [LW-1:0] len,
    input logic [7:0]    mn,
    input logic [7:0]    mx
  );
    kpsc_pkg::cause_t c;
    if (empty) c = kpsc_pkg::CAUSE_EMPTY;
    else if (!in_desc) c = kpsc_pkg::CAUSE_NO_SEP;
    else if (pfx == PFX_BAD) c = kpsc_pkg::CAUSE_PREFIX;
    else if (bad || CW'(len) < CW'(mn) || CW'(len) > CW'(mx)) c = kpsc_pkg::CAUSE_DESC;
    else c = kpsc_pkg::CAUSE_NONE;
    return c;
  endfunction

  // the result register frees up in the same cycle it is taken
  // only a final byte needs it, so other bytes go on while a result waits
  assign q_pop     = q_valid && (!q_data.is_last || !out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    in_desc_nxt   = in_desc_r;
    pfx_nxt       = pfx_r;
    len_nxt       = len_r;
    seg_empty_nxt = seg_empty_r;
    desc_bad_nxt  = desc_bad_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    fin           = kpsc_pkg::CAUSE_NONE;
    if (q_pop) begin
      if (q_data.is_pol_sep) begin
        if (fail_r == kpsc_pkg::CAUSE_NONE) begin
          fail_nxt = seg_cause(seg_empty_r, in_desc_r, pfx_r, desc_bad_r, len_r,
                               bounds.min_len, bounds.max_len);
        end
        in_desc_nxt   = 1'b0;
        pfx_nxt       = PFX_EMPTY;
        len_nxt       = '0;
        seg_empty_nxt = 1'b1;
        desc_bad_nxt  = 1'b0;
      end else begin
        seg_empty_nxt = 1'b0;
        if (!in_desc_r) begin
          if (q_data.is_ref_sep) in_desc_nxt = 1'b1;
          else pfx_nxt = pfx_step(pfx_r, q_data.pfx_cls);
        end else begin
          if (!q_data.is_alnum) desc_bad_nxt = 1'b1;
          if (len_r < LW'(LENGTH_COUNTER_MAX)) len_nxt = len_r + 1'b1;
          else desc_bad_nxt = 1'b1;
        end
      end
      if (q_data.is_last) begin
        fin = fail_nxt;
        if (!q_data.is_pol_sep && fail_nxt == kpsc_pkg::CAUSE_NONE) begin
          fin = seg_cause(seg_empty_nxt, in_desc_nxt, pfx_nxt, desc_bad_nxt, len_nxt,
                          bounds.min_len, bounds.max_len);
        end
        out_valid_nxt           = 1'b1;
        out_data_nxt.policy_ok  = (fin == kpsc_pkg::CAUSE_NONE);
        out_data_nxt.fail_cause = fin;
        in_desc_nxt   = 1'b0;
        pfx_nxt       = PFX_EMPTY;
        len_nxt       = '0;
        seg_empty_nxt = 1'b1;
        desc_bad_nxt  = 1'b0;
        fail_nxt      = kpsc_pkg::CAUSE_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_desc_r   <= 1'b0;
      pfx_r       <= PFX_EMPTY;
      len_r       <= '0;
      seg_empty_r <= 1'b1;
      desc_bad_r  <= 1'b0;
      fail_r      <= kpsc_pkg::CAUSE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      in_desc_r   <= in_desc_nxt;
      pfx_r       <= pfx_nxt;
      len_r       <= len_nxt;
      seg_empty_r <= seg_empty_nxt;
      desc_bad_r  <= desc_bad_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  a_ok_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.policy_ok) |-> (out_data_r.fail_cause == kpsc_pkg::CAUSE_NONE))
    else $error("pass flag with a failure cause");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.is_last) |=>
      (seg_empty_r && !in_desc_r && fail_r == kpsc_pkg::CAUSE_NONE && len_r == '0))
    else $error("parse state not cleared after final byte");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(LENGTH_COUNTER_MAX))
    else $error("descriptor length past counter limit");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(q_pop && q_data.is_last))
    else $error("result without a final byte");

endmodule

[hdl/key_policy_string_checker.sv]
// channel   | signals                          | direction | moves
// ----------+----------------------------------+-----------+-------------------------------
// in        | in_valid in_stall in_data        | input     | one policy byte, last flag
// out       | out_valid out_stall out_data     | output    | pass flag and fail cause
// cfg       | cfg_valid cfg_ready cfg_index    | input     | register index and write data
//           | cfg_data                         |           |
//
// one byte per cycle sustained while in_stall is low; a request is written into the queue,
// the checker pops the final byte once the result register is free and registers the
// verdict there, which raises out_valid
// the byte queue (QUEUE_DEPTH entries) lets bytes keep coming while a result waits
// in_stall is high only while the queue is full; cfg_ready is always high
// synchronous active-low reset restores the register defaults and clears the queue
module key_policy_string_checker #(
  parameter int LENGTH_COUNTER_MAX = kpsc_pkg::LengthCounterMax,
  parameter int QUEUE_DEPTH        = kpsc_pkg::QueueDepth
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  kpsc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output kpsc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kpsc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0]                         cfg_data
);

  logic                  q_full;
  logic                  q_push;
  kpsc_pkg::cls_item_t   q_wdata;
  logic                  q_pop;
  kpsc_pkg::cls_item_t   q_rdata;
  logic                  q_valid;
  kpsc_pkg::len_bounds_t bounds;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  kpsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bounds    (bounds)
  );

  kpsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_valid)
  );

  kpsc_back #(
    .LENGTH_COUNTER_MAX (LENGTH_COUNTER_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .bounds    (bounds),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/key_policy_string_checker_tb.sv]
`timescale 1ns / 100ps

module key_policy_string_checker_tb;

  typedef enum logic [7:0] {
    REG_REF_SEP = 8'd0,
    REG_POL_SEP = 8'd1,
    REG_MIN_LEN = 8'd2,
    REG_MAX_LEN = 8'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PFX_EMPTY,
    PFX_AT,
    PFX_AT_U,
    PFX_AT_US,
    PFX_AT_OTHER,
    PFX_TERMINATED,
    PFX_BAD
  } pfx_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kpsc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kpsc_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kpsc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  key_policy_string_checker u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies, at their reset values
  logic [7:0] ref_sep = 8'd46;
  logic [7:0] pol_sep = 8'd58;
  logic [7:0] min_len = 8'd1;
  logic [7:0] max_len = 8'd64;

  // parser state of the current key reference
  logic             seg_in_desc = 1'b0;
  pfx_state_t       seg_pfx = PFX_EMPTY;
  int               seg_len = 0;
  logic             seg_empty = 1'b1;
  logic             seg_desc_bad = 1'b0;
  kpsc_pkg::cause_t policy_cause = kpsc_pkg::CAUSE_NONE;

  kpsc_pkg::in_item_t  policy_bytes[$];
  logic [7:0]          policy_text[$];
  kpsc_pkg::out_item_t pending_verdicts[$];

  int   idle_pct = 0;
  int   stall_pct = 0;
  int   phase_bytes = 0;
  int   fail_count = 0;
  logic in_taken = 1'b0;
  kpsc_pkg::out_item_t want;

  function automatic pfx_state_t next_prefix_state(pfx_state_t s, logic [7:0] b);
    case (s)
      PFX_EMPTY: return (b == "@") ? PFX_AT : PFX_BAD;
      PFX_AT: begin
        if (b == "u") return PFX_AT_U;
        if (b == "s" || b == "g" || b == "p" || b == "t") return PFX_AT_OTHER;
        return PFX_BAD;
      end
      PFX_AT_U: begin
        if (b == "s") return PFX_AT_US;
        return (b == 8'h00) ? PFX_TERMINATED : PFX_BAD;
      end
      PFX_AT_US, PFX_AT_OTHER: return (b == 8'h00) ? PFX_TERMINATED : PFX_BAD;
      PFX_TERMINATED: return PFX_TERMINATED;
      default: return PFX_BAD;
    endcase
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  task automatic clear_reference();
    seg_in_desc = 1'b0;
    seg_pfx = PFX_EMPTY;
    seg_len = 0;
    seg_empty = 1'b1;
    seg_desc_bad = 1'b0;
  endtask

  task automatic close_reference();
    kpsc_pkg::cause_t c;
    c = kpsc_pkg::CAUSE_NONE;
    if (seg_empty) c = kpsc_pkg::CAUSE_EMPTY;
    else if (!seg_in_desc) c = kpsc_pkg::CAUSE_NO_SEP;
    else if (seg_pfx == PFX_BAD) c = kpsc_pkg::CAUSE_PREFIX;
    else if (seg_desc_bad || seg_len < min_len || seg_len > max_len) c = kpsc_pkg::CAUSE_DESC;
    if (policy_cause == kpsc_pkg::CAUSE_NONE) policy_cause = c;
    clear_reference();
  endtask

  task automatic scan_policy_byte(input kpsc_pkg::in_item_t item);
    logic is_pol;
    kpsc_pkg::out_item_t v;
    is_pol = (item.char_byte == pol_sep);
    if (is_pol) begin
      close_reference();
    end else begin
      seg_empty = 1'b0;
      if (!seg_in_desc) begin
        if (item.char_byte == ref_sep) seg_in_desc = 1'b1;
        else seg_pfx = next_prefix_state(seg_pfx, item.char_byte);
      end else begin
        if (!is_alnum(item.char_byte)) seg_desc_bad = 1'b1;
        // counter saturates, and a descriptor past it is bad
        if (seg_len < kpsc_pkg::LengthCounterMax) seg_len++;
        else seg_desc_bad = 1'b1;
      end
    end
    if (item.is_last) begin
      if (!is_pol) close_reference();
      v.policy_ok = (policy_cause == kpsc_pkg::CAUSE_NONE);
      v.fail_cause = policy_cause;
      pending_verdicts.push_back(v);
      clear_reference();
      policy_cause = kpsc_pkg::CAUSE_NONE;
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (!in_valid || in_taken) begin
        if (policy_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= policy_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: everything sampled on the rising edge
  always @(posedge clk) begin
    in_taken = in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REF_SEP: ref_sep = cfg_data;
          REG_POL_SEP: pol_sep = cfg_data;
          REG_MIN_LEN: min_len = cfg_data;
          REG_MAX_LEN: max_len = cfg_data;
          default: ;
        endcase
      end
      if (in_taken) scan_policy_byte(in_data);
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result: policy_ok %0b fail_cause %0d",
                 out_data.policy_ok, out_data.fail_cause);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_data.policy_ok !== want.policy_ok) begin
            $error("policy_ok: expected %0b, got %0b", want.policy_ok, out_data.policy_ok);
            fail_count++;
          end
          if (out_data.fail_cause !== want.fail_cause) begin
            $error("fail_cause: expected %0d, got %0d", want.fail_cause, out_data.fail_cause);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [7:0] rs, input logic [7:0] ps,
                           input logic [7:0] lo, input logic [7:0] hi);
    write_reg(REG_REF_SEP, rs);
    write_reg(REG_POL_SEP, ps);
    write_reg(REG_MIN_LEN, lo);
    write_reg(REG_MAX_LEN, hi);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // every queued request taken and every verdict back, then let the pipe drain
  task automatic wait_drained();
    do @(negedge clk);
    while (policy_bytes.size() != 0 || in_valid || pending_verdicts.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) policy_text.push_back(s[i]);
  endtask

  task automatic send_policy();
    kpsc_pkg::in_item_t item;
    foreach (policy_text[i]) begin
      item.char_byte = policy_text[i];
      item.is_last = (i == policy_text.size() - 1);
      policy_bytes.push_back(item);
    end
    phase_bytes += policy_text.size();
    policy_text.delete();
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ref_sep || b == pol_sep);
    return b;
  endfunction

  function automatic logic [7:0] alnum_byte();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  task automatic put_keyring_name();
    case ($urandom_range(0, 5))
      0: put_text("@u");
      1: put_text("@us");
      2: put_text("@s");
      3: put_text("@g");
      4: put_text("@p");
      default: put_text("@t");
    endcase
  endtask

  task automatic put_reference();
    int kind;
    int len;
    int hi;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
    end else if (kind < 25) begin
      put_text("@");
    end else if (kind < 70) begin
      put_keyring_name();
    end else if (kind < 80) begin
      put_keyring_name();
      policy_text.push_back(8'h00);
      repeat ($urandom_range(0, 3)) policy_text.push_back(plain_byte());
    end else begin
      repeat ($urandom_range(1, 3)) policy_text.push_back(plain_byte());
    end
    if ($urandom_range(0, 99) < 92) policy_text.push_back(ref_sep);
    kind = $urandom_range(0, 999);
    if (kind < 5) begin
      len = $urandom_range(250, 300);
    end else if (kind < 100) begin
      if (min_len > 0 && $urandom_range(0, 1)) len = min_len - 1;
      else len = (max_len < 255) ? max_len + 1 : max_len;
    end else begin
      hi = (max_len > min_len + 8) ? min_len + 8 : max_len;
      len = (hi < min_len) ? min_len : $urandom_range(min_len, hi);
    end
    repeat (len) begin
      if ($urandom_range(0, 99) < 3) policy_text.push_back(plain_byte());
      else policy_text.push_back(alnum_byte());
    end
  endtask

  task automatic put_random_policy();
    int nref;
    if ($urandom_range(0, 99) < 10) begin
      // noise, separators included
      repeat ($urandom_range(1, 8)) policy_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      nref = $urandom_range(1, 4);
      for (int i = 0; i < nref; i++) begin
        if (i > 0) policy_text.push_back(pol_sep);
        if ($urandom_range(0, 99) >= 4) put_reference();
      end
      if ($urandom_range(0, 99) < 20 || policy_text.size() == 0)
        policy_text.push_back(pol_sep);
    end
    send_policy();
  endtask

  initial begin
    cfg_valid = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests under the reset settings
    put_text("@u.a"); send_policy();
    put_text("@us"); policy_text.push_back(8'h00); put_text("x.Z9:"); send_policy();
    put_text(":"); send_policy();
    put_text("::a.b"); send_policy();
    put_text("@x.a:..b"); send_policy();
    put_text("."); send_policy();
    policy_text.push_back(8'hFF); send_policy();
    policy_text.push_back(8'h00); send_policy();
    put_text(".a.b"); send_policy();
    put_text("ab:@g.c"); send_policy();

    for (int p = 0; p < 9; p++) begin
      wait_drained();
      case (p)
        0: configure(8'd46, 8'd58, 8'd1, 8'd64);
        1: configure(8'd46, 8'd58, 8'd0, 8'd255);
        2: configure(8'd0, 8'd255, 8'd3, 8'd6);
        3: configure(8'd255, 8'd0, 8'd1, 8'd64);
        4: configure(8'd58, 8'd58, 8'd1, 8'd8);
        5: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0, 8'd0);
        6: configure(8'd46, 8'd58, 8'd250, 8'd255);
        7: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd5, 8'd2);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 75; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 75; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 210) put_random_policy();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d results never arrived", pending_verdicts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
